### hdl/sfhc_pkg.sv
package sfhc_pkg;

    localparam int CfgAddrWidth = 4;
    localparam int CfgDataWidth = 32;

    localparam logic [7:0] MIN_FRAME_LENGTH = 8'd4;
    localparam logic [7:0] FIRST_ID_POS     = 8'd3;
    localparam logic [7:0] INDEX_MAX        = 8'hff;
    localparam logic [7:0] TAIL_ZERO        = 8'h00;
    localparam logic [7:0] TAIL_ONES        = 8'hff;
    localparam logic [6:0] TYPE_MASK        = 7'h7f;

    localparam logic [7:0] RESET_MAX_FRAME_SIZE = 8'd63;
    localparam logic [3:0] RESET_MAX_ID_LENGTH  = 4'd8;
    localparam logic [7:0] RESET_TYPE_LIMIT     = 8'd127;

    typedef enum logic [1:0] {
        REG_MAX_FRAME_SIZE = 2'd0,
        REG_MAX_ID_LENGTH  = 2'd1,
        REG_TYPE_LIMIT     = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ERR_OK             = 4'd0,
        ERR_SHORT_BUFFER   = 4'd1,
        ERR_FL_SMALL       = 4'd2,
        ERR_FL_BIG         = 4'd3,
        ERR_BAD_TYPE       = 4'd4,
        ERR_IL_BIG         = 4'd5,
        ERR_IL_OVER_FRAME  = 4'd6,
        ERR_HDR_TRUNCATED  = 4'd7,
        ERR_BL_BIG         = 4'd8,
        ERR_BAD_LAST_BYTE  = 4'd9,
        ERR_TRAILER_LENGTH = 4'd10
    } err_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [3:0]  error_code;
        logic [3:0]  header_length;
        logic [7:0]  frame_length;
        logic [7:0]  frame_type;
        logic        secure;
        logic [3:0]  sequence_res;
        logic [3:0]  id_length;
        logic [63:0] id_bytes;
        logic [7:0]  body_length;
        logic [7:0]  trailer_length;
    } out_item_t;

    typedef struct packed {
        logic [7:0] max_frame_size;
        logic [3:0] max_id_length;
        logic [7:0] type_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  buf_len;
        logic [7:0]  length_byte;
        logic [7:0]  type_byte;
        logic [7:0]  seq_and_idlen;
        logic [7:0]  body_len_byte;
        logic        tail_seen;
        logic        tail_bad;
        logic [63:0] id_bytes;
    } frame_snap_t;

endpackage

### hdl/small_frame_header_checker.sv
// Checks the header of a small radio frame streamed in one byte per transaction, starting
// with the length byte; last_byte marks the end of the buffer. Bytes are taken at one per
// clock with no gaps needed while s_ready is high. On the final byte the captured header
// moves into a snapshot register; the integrity checks run on it and the result lands in
// the output register once that register is free. s_ready drops
// only when both the snapshot and the output register hold undelivered results. The
// limits come from three registers on the APB port at byte addresses 0, 4 and 8 and
// should be written while no frame is in flight.
module small_frame_header_checker import sfhc_pkg::*; #(
    parameter int ID_STORE_BYTES = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_item_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output out_item_t               m_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [CfgDataWidth-1:0] pwdata,
    output logic [CfgDataWidth-1:0] prdata,
    output logic                    pready
);

    cfg_t        cfg_reg, cfg_next;
    reg_index_t  reg_sel;
    logic        cfg_wr;
    logic        byte_en;
    logic        snap_valid;
    logic        snap_take;
    frame_snap_t snap;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            REG_MAX_FRAME_SIZE: begin
                prdata = {24'd0, cfg_reg.max_frame_size};
                if (cfg_wr) cfg_next.max_frame_size = pwdata[7:0];
            end
            REG_MAX_ID_LENGTH: begin
                prdata = {28'd0, cfg_reg.max_id_length};
                if (cfg_wr) cfg_next.max_id_length = pwdata[3:0];
            end
            REG_TYPE_LIMIT: begin
                prdata = {24'd0, cfg_reg.type_limit};
                if (cfg_wr) cfg_next.type_limit = pwdata[7:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_size <= RESET_MAX_FRAME_SIZE;
            cfg_reg.max_id_length  <= RESET_MAX_ID_LENGTH;
            cfg_reg.type_limit     <= RESET_TYPE_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !snap_valid || snap_take;
    assign byte_en = s_valid && s_ready;

    sfhc_capture #(
        .ID_STORE_BYTES(ID_STORE_BYTES)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .item      (s_data),
        .snap_take (snap_take),
        .snap_valid(snap_valid),
        .snap      (snap)
    );

    sfhc_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .snap_valid(snap_valid),
        .snap      (snap),
        .cfg       (cfg_reg),
        .snap_take (snap_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hdl/sfhc_capture.sv
module sfhc_capture import sfhc_pkg::*; #(
    parameter int ID_STORE_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  in_item_t    item,
    input  logic        snap_take,
    output logic        snap_valid,
    output frame_snap_t snap
);

    logic [7:0]  byte_index_reg, byte_index_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  body_reg, body_next;
    logic        tail_seen_reg, tail_seen_next;
    logic        tail_bad_reg, tail_bad_next;
    logic [7:0]  id_store_reg [ID_STORE_BYTES];
    logic [7:0]  id_next [ID_STORE_BYTES];
    logic        snap_valid_reg, snap_valid_next;
    frame_snap_t snap_reg, snap_next;
    logic [7:0]  id_pos;
    logic [7:0]  il;
    logic        id_wr;
    logic [63:0] snap_ids;

    assign id_pos = byte_index_reg - FIRST_ID_POS;
    assign il     = {4'd0, seq_reg[3:0]};

    always_comb begin
        byte_index_next = byte_index_reg;
        length_next     = length_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        body_next       = body_reg;
        tail_seen_next  = tail_seen_reg;
        tail_bad_next   = tail_bad_reg;
        id_wr           = 1'b0;
        if (byte_en && byte_index_reg != INDEX_MAX) begin
            byte_index_next = byte_index_reg + 8'd1;
            if (byte_index_reg == 8'd0) begin
                length_next = item.data_byte;
            end else if (byte_index_reg == 8'd1) begin
                type_next = item.data_byte;
            end else if (byte_index_reg == 8'd2) begin
                seq_next = item.data_byte;
            end else if (id_pos < il) begin
                id_wr = 1'b1;
            end else if (id_pos == il) begin
                body_next = item.data_byte;
            end
            if (byte_index_reg != 8'd0 && byte_index_reg == length_reg) begin
                tail_seen_next = 1'b1;
                tail_bad_next  = (item.data_byte == TAIL_ZERO) ||
                                 (item.data_byte == TAIL_ONES);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < ID_STORE_BYTES; i++) begin
            id_next[i] = (id_wr && id_pos == 8'(i)) ? item.data_byte : id_store_reg[i];
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_ids
        if (j < ID_STORE_BYTES) begin : g_stored
            assign snap_ids[8*j +: 8] = id_next[j];
        end else begin : g_absent
            assign snap_ids[8*j +: 8] = 8'd0;
        end
    end

    always_comb begin
        snap_next.buf_len       = byte_index_next;
        snap_next.length_byte   = length_next;
        snap_next.type_byte     = type_next;
        snap_next.seq_and_idlen = seq_next;
        snap_next.body_len_byte = body_next;
        snap_next.tail_seen     = tail_seen_next;
        snap_next.tail_bad      = tail_bad_next;
        snap_next.id_bytes      = snap_ids;
        if (byte_en && item.last_byte) begin
            snap_valid_next = 1'b1;
        end else if (snap_take) begin
            snap_valid_next = 1'b0;
        end else begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            length_reg     <= '0;
            type_reg       <= '0;
            seq_reg        <= '0;
            body_reg       <= '0;
            tail_seen_reg  <= 1'b0;
            tail_bad_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            if (byte_en && item.last_byte) begin
                byte_index_reg <= '0;
                length_reg     <= '0;
                type_reg       <= '0;
                seq_reg        <= '0;
                body_reg       <= '0;
                tail_seen_reg  <= 1'b0;
                tail_bad_reg   <= 1'b0;
            end else begin
                byte_index_reg <= byte_index_next;
                length_reg     <= length_next;
                type_reg       <= type_next;
                seq_reg        <= seq_next;
                body_reg       <= body_next;
                tail_seen_reg  <= tail_seen_next;
                tail_bad_reg   <= tail_bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ID_STORE_BYTES; i++) begin
            id_store_reg[i] <= id_next[i];
        end
        if (byte_en && item.last_byte) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

### hdl/sfhc_check.sv
module sfhc_check import sfhc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        snap_valid,
    input  frame_snap_t snap,
    input  cfg_t        cfg,
    output logic        snap_take,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;
    err_code_t  err;
    logic [7:0] fl;
    logic [3:0] il4;
    logic [7:0] il;
    logic [7:0] ftype;
    logic [7:0] fl_room;
    logic [7:0] bl_room;
    logic [7:0] tl;
    logic [8:0] hdr_len;

    assign fl      = snap.length_byte;
    assign il4     = snap.seq_and_idlen[3:0];
    assign il      = {4'd0, il4};
    assign ftype   = {1'b0, snap.type_byte[6:0] & TYPE_MASK};
    assign fl_room = fl - MIN_FRAME_LENGTH;
    assign bl_room = fl_room - il;
    assign tl      = bl_room - snap.body_len_byte + 8'd1;
    assign hdr_len = {1'b0, il} + {1'b0, MIN_FRAME_LENGTH};

    always_comb begin
        if (snap.buf_len < MIN_FRAME_LENGTH) begin
            err = ERR_SHORT_BUFFER;
        end else if (fl < MIN_FRAME_LENGTH) begin
            err = ERR_FL_SMALL;
        end else if (fl > cfg.max_frame_size) begin
            err = ERR_FL_BIG;
        end else if (ftype == 8'd0 || ftype >= cfg.type_limit) begin
            err = ERR_BAD_TYPE;
        end else if (il4 > cfg.max_id_length) begin
            err = ERR_IL_BIG;
        end else if (il > fl_room) begin
            err = ERR_IL_OVER_FRAME;
        end else if (hdr_len > {1'b0, snap.buf_len}) begin
            err = ERR_HDR_TRUNCATED;
        end else if (snap.body_len_byte > bl_room) begin
            err = ERR_BL_BIG;
        end else if (snap.tail_seen && snap.tail_bad) begin
            err = ERR_BAD_LAST_BYTE;
        end else if (!snap.type_byte[7] && tl != 8'd1) begin
            err = ERR_TRAILER_LENGTH;
        end else if (snap.type_byte[7] && tl == 8'd0) begin
            err = ERR_TRAILER_LENGTH;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        m_data_next            = '0;
        m_data_next.error_code = err;
        if (err == ERR_OK) begin
            m_data_next.valid_res      = 1'b1;
            m_data_next.header_length  = il4 + 4'd4;
            m_data_next.frame_length   = fl;
            m_data_next.frame_type     = snap.type_byte;
            m_data_next.secure         = snap.type_byte[7];
            m_data_next.sequence_res   = snap.seq_and_idlen[7:4];
            m_data_next.id_length      = il4;
            m_data_next.body_length    = snap.body_len_byte;
            m_data_next.trailer_length = tl;
            for (int j = 0; j < 8; j++) begin
                if (4'(j) < il4) begin
                    m_data_next.id_bytes[8*j +: 8] = snap.id_bytes[8*j +: 8];
                end
            end
        end
    end

    assign snap_take = snap_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (snap_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_take) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |-> m_data.error_code == ERR_OK)
        else $error("passing result carries an error code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |->
            m_data.frame_length == 8'd0 && m_data.id_bytes == 64'd0 &&
            m_data.trailer_length == 8'd0 && m_data.error_code != ERR_OK)
        else $error("failing result carries header fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |->
            m_data.header_length == m_data.id_length + 4'd4)
        else $error("header length does not match id length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        snap_take |=> m_valid)
        else $error("transaction taken from snapshot but no result shown");

endmodule
